[design/gnsb_pkg.sv]
// ----------------------------------------------------------------------------
// gnsb_pkg
// Shared sizes, codes and types of the nearest-source grid search.
// ----------------------------------------------------------------------------
`default_nettype none
package gnsb_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int MAX_CELLS = 4096;
  localparam int CW        = $clog2(MAX_SIDE);
  localparam int AW        = $clog2(MAX_CELLS);
  localparam int SW        = 7;
  localparam int DW        = 7;
  localparam int QW        = 2 * CW;

  localparam logic [DW-1:0] UNREACHED = 7'd127;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COUNT = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MV_SELF,
    MV_DOWN,
    MV_UP,
    MV_RIGHT,
    MV_LEFT
  } move_t;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic [AW-1:0] idx;
  } nbr_t;

endpackage
`default_nettype wire

[design/gnsb_ram.sv]
// ----------------------------------------------------------------------------
// gnsb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gnsb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/gnsb_nbr.sv]
// ----------------------------------------------------------------------------
// gnsb_nbr
// Neighbor unit: steps one cell in a direction, checks the grid edge and
// forms the row-major index with the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module gnsb_nbr import gnsb_pkg::*; (
  input  wire logic [CW-1:0] x,
  input  wire logic [CW-1:0] y,
  input  wire move_t         move,
  input  wire logic [SW-1:0] width,
  input  wire logic [SW-1:0] height,
  output nbr_t               nb
);

  logic [AW:0] prod;

  always_comb begin
    nb.ok = 1'b1;
    nb.nx = x;
    nb.ny = y;
    unique case (move)
      MV_SELF: begin
      end
      MV_DOWN: begin
        nb.ok = (SW'(y) + SW'(1)) < height;
        nb.ny = y + CW'(1);
      end
      MV_UP: begin
        nb.ok = (y != '0);
        nb.ny = y - CW'(1);
      end
      MV_RIGHT: begin
        nb.ok = (SW'(x) + SW'(1)) < width;
        nb.nx = x + CW'(1);
      end
      MV_LEFT: begin
        nb.ok = (x != '0);
        nb.nx = x - CW'(1);
      end
      default: nb.ok = 1'b0;
    endcase
    prod   = (AW+1)'(nb.ny) * (AW+1)'(width) + (AW+1)'(nb.nx);
    nb.idx = prod[AW-1:0];
  end

endmodule
`default_nettype wire

[design/grid_nearest_source_bfs.sv]
// ----------------------------------------------------------------------------
// grid_nearest_source_bfs
// Multi-source breadth-first distance transform over a loaded grid.
// ----------------------------------------------------------------------------
// A load word goes straight to the response state; a read word first waits
// for the registered RAM read. A run sweeps all 4096 distance entries, then
// scans the loaded cells in a seed read and a seed write state each, then pops
// every reached cell (pop, pop-wait, current-wait) and for each of its four
// neighbors reads it and, inside the grid, checks it, all through one RAM read
// port and one shared multiplier. After reset the same sweep runs before any word.
`default_nettype none
module grid_nearest_source_bfs import gnsb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // is_source, cell_index, zero pad
  input  wire logic [1:0]  s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // status, distance, nearest_source, reached, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD_WAIT, S_CLR, S_SEED_RD, S_SEED_WR,
    S_POP, S_POP_WAIT, S_CUR_WAIT, S_NB_RD, S_NB_CHK, S_RESP
  } state_t;

  state_t        state;
  logic [SW-1:0] width, height;
  logic [AW:0]   cnt, ptr, head, tail;
  logic [CW-1:0] sx, sy, cx, cy;
  logic [DW-1:0] cd;
  logic [AW-1:0] cn;
  logic [1:0]    dir;
  nbr_t          nbl;
  status_t       res_st;
  logic [DW-1:0] res_d;
  logic [AW-1:0] res_n;
  logic          res_r;

  logic          src_we, src_wd, src_rd;
  logic [AW-1:0] src_waddr, src_raddr;
  logic          d_we, n_we, q_we;
  logic [AW-1:0] m_waddr, m_raddr, q_waddr, q_raddr, n_wd, n_rd;
  logic [DW-1:0] d_wd, d_rd;
  logic [QW-1:0] q_wd, q_rd;
  logic [CW-1:0] nx_in, ny_in;
  move_t         mv;
  nbr_t          nb;
  logic [2*SW-1:0] cells;
  logic          accept, dim_ok, rd_range;
  op_t           op;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign op        = op_t'(s_tuser);
  assign cells     = width * height;
  assign dim_ok    = (width != '0) && (height != '0) && (width <= SW'(MAX_SIDE))
                     && (height <= SW'(MAX_SIDE)) && ((AW+1)'(cells) == cnt)
                     && (cells <= (2*SW)'(MAX_CELLS));
  assign rd_range  = (2*SW)'(s_tdata[12:1]) >= cells;

  always_comb begin
    nx_in = (state == S_POP_WAIT) ? q_rd[CW-1:0]  : cx;
    ny_in = (state == S_POP_WAIT) ? q_rd[QW-1:CW] : cy;
    if (state == S_POP_WAIT) begin
      mv = MV_SELF;
    end else begin
      unique case (dir)
        2'd0: mv = MV_DOWN;
        2'd1: mv = MV_UP;
        2'd2: mv = MV_RIGHT;
        2'd3: mv = MV_LEFT;
      endcase
    end
  end

  gnsb_nbr u_nbr (
    .x(nx_in), .y(ny_in), .move(mv), .width(width), .height(height), .nb(nb)
  );

  always_comb begin
    src_we    = 1'b0;
    src_waddr = cnt[AW-1:0];
    src_wd    = s_tdata[0];
    src_raddr = ptr[AW-1:0];
    d_we      = 1'b0;
    n_we      = 1'b0;
    q_we      = 1'b0;
    m_waddr   = ptr[AW-1:0];
    m_raddr   = s_tdata[12:1];
    d_wd      = UNREACHED;
    n_wd      = ptr[AW-1:0];
    q_waddr   = tail[AW-1:0];
    q_wd      = {sy, sx};
    q_raddr   = head[AW-1:0];
    unique case (state)
      S_IDLE: begin
        src_we = accept && (op == OP_LOAD) && (cnt < (AW+1)'(MAX_CELLS));
      end
      S_INIT, S_CLR: begin
        d_we = 1'b1;
      end
      S_SEED_WR: begin
        d_we = src_rd;
        n_we = src_rd;
        q_we = src_rd;
        d_wd = '0;
      end
      S_POP_WAIT: begin
        m_raddr = nb.idx;
      end
      S_NB_RD: begin
        m_raddr = nb.idx;
      end
      S_NB_CHK: begin
        d_we    = (d_rd == UNREACHED);
        n_we    = (d_rd == UNREACHED);
        q_we    = (d_rd == UNREACHED);
        m_waddr = nbl.idx;
        d_wd    = cd;
        n_wd    = cn;
        q_wd    = {nbl.ny, nbl.nx};
      end
      default: begin
      end
    endcase
  end

  gnsb_ram #(.DEPTH(MAX_CELLS), .WIDTH(1)) u_src (
    .clk(clk), .we(src_we), .waddr(src_waddr), .wdata(src_wd),
    .raddr(src_raddr), .rdata(src_rd)
  );
  gnsb_ram #(.DEPTH(MAX_CELLS), .WIDTH(DW)) u_dist (
    .clk(clk), .we(d_we), .waddr(m_waddr), .wdata(d_wd),
    .raddr(m_raddr), .rdata(d_rd)
  );
  gnsb_ram #(.DEPTH(MAX_CELLS), .WIDTH(AW)) u_near (
    .clk(clk), .we(n_we), .waddr(m_waddr), .wdata(n_wd),
    .raddr(m_raddr), .rdata(n_rd)
  );
  gnsb_ram #(.DEPTH(MAX_CELLS), .WIDTH(QW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wd),
    .raddr(q_raddr), .rdata(q_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      width    <= SW'(MAX_SIDE);
      height   <= SW'(MAX_SIDE);
      cnt      <= '0;
      ptr      <= '0;
      head     <= '0;
      tail     <= '0;
      dir      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index) begin
          height <= cfg_data;
        end else begin
          width <= cfg_data;
        end
      end
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      if (src_we) begin
        cnt <= cnt + 1'b1;
      end
      if (q_we) begin
        tail <= tail + 1'b1;
      end
      unique case (state)
        S_INIT, S_CLR: begin
          if (ptr[AW-1:0] == '1) begin
            ptr   <= '0;
            sx    <= '0;
            sy    <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_SEED_RD;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          res_d  <= '0;
          res_n  <= '0;
          res_r  <= 1'b0;
          if (accept && (op == OP_RUN) && !dim_ok) begin
            res_st <= ST_COUNT;
          end else if (accept && (op == OP_READ) && rd_range) begin
            res_st <= ST_RANGE;
          end else begin
            res_st <= ST_OK;
          end
          if (accept) begin
            priority case (op)
              OP_RUN: begin
                if (dim_ok) begin
                  head  <= '0;
                  tail  <= '0;
                  ptr   <= '0;
                  state <= S_CLR;
                end else begin
                  state <= S_RESP;
                end
              end
              OP_READ: begin
                if (rd_range) begin
                  state <= S_RESP;
                end else begin
                  state <= S_RD_WAIT;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_RD_WAIT: begin
          if (d_rd != UNREACHED) begin
            res_d <= d_rd;
            res_n <= n_rd;
            res_r <= 1'b1;
          end
          state <= S_RESP;
        end
        S_SEED_RD: state <= S_SEED_WR;
        S_SEED_WR: begin
          ptr <= ptr + 1'b1;
          if ((SW'(sx) + SW'(1)) == width) begin
            sx <= '0;
            sy <= sy + CW'(1);
          end else begin
            sx <= sx + CW'(1);
          end
          state <= ((2*SW)'(ptr) + (2*SW)'(1) == cells) ? S_POP : S_SEED_RD;
        end
        S_POP: begin
          if (head == tail) begin
            state <= S_RESP;
          end else begin
            head  <= head + 1'b1;
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          cx    <= q_rd[CW-1:0];
          cy    <= q_rd[QW-1:CW];
          state <= S_CUR_WAIT;
        end
        S_CUR_WAIT: begin
          cd    <= d_rd + DW'(1);
          cn    <= n_rd;
          dir   <= '0;
          state <= S_NB_RD;
        end
        S_NB_RD: begin
          nbl <= nb;
          if (nb.ok) begin
            state <= S_NB_CHK;
          end else begin
            dir   <= dir + 2'd1;
            state <= (dir == 2'd3) ? S_POP : S_NB_RD;
          end
        end
        S_NB_CHK: begin
          dir   <= dir + 2'd1;
          state <= (dir == 2'd3) ? S_POP : S_NB_RD;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_r, res_n, res_d, res_st};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= (AW+1)'(MAX_CELLS))
    else $error("queue overflow");
  a_reach_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[21]) |-> (m_tdata[1:0] == ST_OK))
    else $error("reached result with error status");
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB_CHK) |-> !s_tready)
    else $error("input accepted during search");

endmodule
`default_nettype wire
